### sv/sliding_median_alert_core_assert.svh
// assertion macros for the sliding median alert core
// expects signals named clk and rst in the including scope
`ifndef SLIDING_MEDIAN_ALERT_CORE_ASSERT_SVH
`define SLIDING_MEDIAN_ALERT_CORE_ASSERT_SVH

// same-cycle implication
`define SMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sliding median alert core: check failed");

// next-cycle implication
`define SMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sliding median alert core: check failed");

`endif

### sv/sma_pkg.sv
// shared types and constants of the sliding median alert core
// no dependencies
package sma_pkg;

  // window storage depth
  localparam int MAX_WINDOW = 32;
  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int NLEN_W     = $clog2(MAX_WINDOW + 1);

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 6;
  localparam int DM_W       = 17;
  localparam int COUNT_W    = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_FLD_W  = 1 + DM_W + COUNT_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

  // sequencer states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SHIFT
  } sma_state_t;

  // broadcast control to every cell
  typedef struct packed {
    logic                capture;  // latch the drop mark
    logic                commit;   // load the new sorted value
    logic                del;      // window full: one entry leaves
    logic [SAMPLE_W-1:0] drop;     // value of the oldest sample
    logic [SAMPLE_W-1:0] ins;      // value being inserted
  } sma_ctl_t;

  // link from a cell to the cell above it
  typedef struct packed {
    logic                lt;   // this position stays below the inserted value
    logic [SAMPLE_W-1:0] sel;  // value here after the drop is closed up
  } sma_link_t;

endpackage

### sv/sma_cell.sv
// one position of the sorted window: holds a value and a drop mark
// depends on sma_pkg
module sma_cell (
  input  logic                         clk,
  input  sma_pkg::sma_ctl_t            ctl,
  input  logic                         keep,    // position below closed-up length
  input  sma_pkg::sma_link_t           lo,      // from the cell below
  input  logic [sma_pkg::SAMPLE_W-1:0] hi_val,  // value of the cell above
  output logic [sma_pkg::SAMPLE_W-1:0] val,
  output sma_pkg::sma_link_t           link
);

  logic                         drop_mark;
  logic [sma_pkg::SAMPLE_W-1:0] sel;
  logic                         lt;
  logic [sma_pkg::SAMPLE_W-1:0] val_next;

  // close up the gap of the dropped entry, then place the new one
  always_comb begin
    sel = drop_mark ? hi_val : val;
    lt  = keep && !(sel > ctl.ins);
    if (lt) begin
      val_next = sel;
    end else if (lo.lt) begin
      val_next = ctl.ins;
    end else begin
      val_next = lo.sel;
    end
  end

  assign link.lt  = lt;
  assign link.sel = sel;

  // drop mark: at or above the dropped entry when the window slides; value loaded on commit
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      drop_mark <= ctl.del && (val >= ctl.drop);
    end
    if (ctl.commit) begin
      val <= val_next;
    end
  end

endmodule

### sv/sliding_median_alert_core.sv
// sliding median alert core: top level, sequencer, arrival ring, result register
// depends on sma_pkg, sma_cell and sliding_median_alert_core_assert.svh
//
//   channel | dir | handshake           | payload
//   s       | in  | s_tvalid / s_tready | s_tdata: sample; s_tlast: last
//   m       | out | m_tvalid / m_tready | m_tdata: alert, median_x2, alert_count
//           |     |                     | m_tuser: warming
//   cfg     | in  | cfg_valid/cfg_ready | cfg_data: window_len
//
// per word: the accept cycle reads the median and marks the oldest
// entry in every cell, then the ST_SHIFT state shifts the cell row.
// the shift holds while the result register is full and not taken;
// a new word is taken while a finished result still waits.
// rst clears the series state and sets window_len to 1.
`include "sliding_median_alert_core_assert.svh"

module sliding_median_alert_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sma_pkg::IN_DATA_W-1:0]  s_tdata,   // [15:0] sample
  input  logic                           s_tlast,   // last
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sma_pkg::OUT_DATA_W-1:0] m_tdata,   // [0] alert, [17:1] median_x2,
                                                    // [33:18] alert_count, rest zero
  output logic [0:0]                     m_tuser,   // [0] warming
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sma_pkg::CFG_W-1:0]      cfg_data
);

  localparam int W  = sma_pkg::MAX_WINDOW;
  localparam int SW = sma_pkg::SAMPLE_W;
  localparam int NW = sma_pkg::NLEN_W;
  localparam int TW = sma_pkg::SLOT_W;

  sma_pkg::sma_state_t state, state_next;

  logic [sma_pkg::CFG_W-1:0]   window_len;
  logic [NW-1:0]               fill;
  logic [TW-1:0]               oldest;
  logic [sma_pkg::COUNT_W-1:0] alert_total;

  logic [SW-1:0]               ring [W];

  logic [SW-1:0]               cur_sample;
  logic                        cur_last;
  logic                        cur_alert;
  logic                        cur_warm;
  logic [sma_pkg::DM_W-1:0]    cur_dm;

  logic                        out_valid;
  logic                        out_alert;
  logic                        out_warm;
  logic [sma_pkg::DM_W-1:0]    out_dm;
  logic [sma_pkg::COUNT_W-1:0] out_count;

  logic                        accept;
  logic                        cfg_write;
  logic                        commit;
  logic                        capture;

  logic [NW-1:0]               n_eff;
  logic                        full;
  logic [NW-1:0]               len_c;
  logic [TW-1:0]               lo_idx;
  logic [TW-1:0]               hi_idx;
  logic [sma_pkg::DM_W-1:0]    dm_full;
  logic [sma_pkg::DM_W-1:0]    dm;
  logic                        alert_now;
  logic [sma_pkg::COUNT_W-1:0] count_upd;
  logic [TW-1:0]               wr_slot;
  logic [NW-1:0]               oldest_inc;

  logic [SW-1:0]               cell_val  [W];
  sma_pkg::sma_link_t          cell_link [W];
  logic [W-1:0]                keep;
  sma_pkg::sma_ctl_t           ctl;

  // effective window length
  always_comb begin
    if (window_len == '0) begin
      n_eff = NW'(1);
    end else if (32'(window_len) > 32'(W)) begin
      n_eff = NW'(W);
    end else begin
      n_eff = NW'(window_len);
    end
  end

  assign full  = (fill == n_eff);
  assign len_c = full ? (fill - NW'(1)) : fill;

  // median taps and threshold
  assign lo_idx    = TW'((n_eff - NW'(1)) >> 1);
  assign hi_idx    = TW'(n_eff >> 1);
  assign dm_full   = sma_pkg::DM_W'(cell_val[lo_idx]) + sma_pkg::DM_W'(cell_val[hi_idx]);
  assign dm        = full ? dm_full : '0;
  assign alert_now = full && (sma_pkg::DM_W'(s_tdata[SW-1:0]) >= dm_full);

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      sma_pkg::ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          state_next = sma_pkg::ST_SHIFT;
        end
      end
      sma_pkg::ST_SHIFT: begin
        if (!out_valid || m_tready) begin
          state_next = sma_pkg::ST_IDLE;
        end
      end
      default: state_next = sma_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    cfg_ready = 1'b0;
    commit    = 1'b0;
    unique case (state)
      sma_pkg::ST_IDLE: begin
        s_tready  = !cfg_valid;
        cfg_ready = 1'b1;
      end
      sma_pkg::ST_SHIFT: begin
        commit = !out_valid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign accept    = s_tvalid && s_tready;
  assign cfg_write = cfg_valid && cfg_ready;
  assign capture   = accept;

  // cell control
  assign ctl.capture = capture;
  assign ctl.commit  = commit;
  assign ctl.del     = full;
  assign ctl.drop    = ring[oldest];
  assign ctl.ins     = cur_sample;

  // row of sorted cells
  for (genvar i = 0; i < W; i++) begin : g_cell
    sma_pkg::sma_link_t lo_link;
    logic [SW-1:0]      hi_v;

    assign keep[i] = (NW'(i) < len_c);

    if (i == 0) begin : g_first
      assign lo_link.lt  = 1'b1;
      assign lo_link.sel = '0;
    end else begin : g_mid
      assign lo_link = cell_link[i-1];
    end

    if (i == W - 1) begin : g_top
      assign hi_v = '0;
    end else begin : g_below
      assign hi_v = cell_val[i+1];
    end

    sma_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .keep   (keep[i]),
      .lo     (lo_link),
      .hi_val (hi_v),
      .val    (cell_val[i]),
      .link   (cell_link[i])
    );
  end

  // slot bookkeeping
  assign wr_slot    = full ? oldest : TW'(fill);
  assign oldest_inc = NW'(oldest) + NW'(1);
  assign count_upd  = (cur_alert && (alert_total != '1)) ?
                      alert_total + sma_pkg::COUNT_W'(1) : alert_total;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sma_pkg::ST_IDLE;
      window_len  <= sma_pkg::CFG_W'(1);
      fill        <= '0;
      oldest      <= '0;
      alert_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        window_len  <= cfg_data;
        fill        <= '0;
        oldest      <= '0;
        alert_total <= '0;
      end else if (commit) begin
        if (cur_last) begin
          fill        <= '0;
          oldest      <= '0;
          alert_total <= '0;
        end else begin
          alert_total <= count_upd;
          if (!cur_warm) begin
            oldest <= (oldest_inc == n_eff) ? '0 : TW'(oldest_inc);
          end else begin
            fill <= fill + NW'(1);
          end
        end
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_sample <= s_tdata[SW-1:0];
      cur_last   <= s_tlast;
      cur_alert  <= alert_now;
      cur_warm   <= !full;
      cur_dm     <= dm;
    end
    if (commit) begin
      ring[wr_slot] <= cur_sample;
      out_alert     <= cur_alert;
      out_warm      <= cur_warm;
      out_dm        <= cur_dm;
      out_count     <= count_upd;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{sma_pkg::OUT_PAD_W{1'b0}}, out_count, out_dm, out_alert};
  assign m_tuser  = out_warm;

  // checks
  `SMA_ASSERT_NOW(a_fill_in_window, 1'b1, fill <= n_eff)
  `SMA_ASSERT_NOW(a_oldest_in_window, 1'b1, NW'(oldest) < n_eff)
  `SMA_ASSERT_NOW(a_warm_no_alert, m_tvalid && m_tuser[0], !m_tdata[0] && m_tdata[17:1] == '0)
  `SMA_ASSERT_NEXT(a_last_clears, commit && cur_last, fill == '0 && alert_total == '0)
  `SMA_ASSERT_NEXT(a_accept_shifts, accept, state == sma_pkg::ST_SHIFT)

endmodule
